@@ src/ppid_pkg.sv @@
`timescale 1ns / 1ps

package ppid_pkg;

	// Register file of the configuration channel
	typedef enum logic [2:0] {
		CFG_TARGET      = 3'd0,
		CFG_OUT_LIMIT   = 3'd1,
		CFG_KP          = 3'd2,
		CFG_KI          = 3'd3,
		CFG_KD          = 3'd4,
		CFG_MIN_DRIVE   = 3'd5,
		CFG_INT_LIMIT   = 3'd6,
		CFG_TIMEOUT     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_MOVING  = 2'd0,
		ST_REACHED = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	// Control that rides along with one request through the product stage
	typedef struct packed {
		logic    run;        // controller drives on this tick
		logic    above_tol;  // error magnitude strictly above the tolerance band
		status_t status;
	} drive_ctrl_t;

	localparam int POS_W   = 24;
	localparam int TGT_W   = 24;
	localparam int VOLT_W  = 14;
	localparam int GAIN_W  = 16;
	localparam int ILIM_W  = 20;
	localparam int TICK_W  = 16;
	localparam int DRIVE_W = 15;
	localparam int CFG_D_W = 24;

	localparam int ERR_W   = 27;  // error in half degrees
	localparam int ESUM_W  = 22;  // clamped integral, bounded by twice the integral limit
	localparam int DIFF_W  = 28;
	localparam int SUM_W   = 46;

	localparam int TOLERANCE_DEF = 5;
	localparam int GAIN_FRAC_DEF = 8;

	localparam logic [TGT_W-1:0]  TARGET_RST    = '0;
	localparam logic [VOLT_W-1:0] OUT_LIMIT_RST = 14'd12000;
	localparam logic [GAIN_W-1:0] KP_RST        = 16'd2304;
	localparam logic [GAIN_W-1:0] KI_RST        = 16'd0;
	localparam logic [GAIN_W-1:0] KD_RST        = 16'd25600;
	localparam logic [VOLT_W-1:0] MIN_DRIVE_RST = 14'd1500;
	localparam logic [ILIM_W-1:0] INT_LIMIT_RST = 20'd3000;
	localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd300;

endpackage

@@ src/ppid_drive.sv @@
`timescale 1ns / 1ps

module ppid_drive
	import ppid_pkg::*;
#(
	parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [GAIN_W-1:0]         kp,
	input  logic [GAIN_W-1:0]         ki,
	input  logic [GAIN_W-1:0]         kd,
	input  logic [VOLT_W-1:0]         out_limit,
	input  logic [VOLT_W-1:0]         min_drive,
	input  logic signed [ERR_W-1:0]   err,
	input  logic signed [ESUM_W-1:0]  esum,
	input  logic signed [DIFF_W-1:0]  diff,
	input  drive_ctrl_t               ctrl,
	output logic signed [DRIVE_W-1:0] drive,
	output status_t                   status
);

	localparam int SCALE = GAIN_FRACTION_BITS + 1;
	localparam int LIM_W = VOLT_W + SCALE + 1;

	logic signed [GAIN_W+ERR_W:0]  p_s3;
	logic signed [GAIN_W+ESUM_W:0] i_s3;
	logic signed [GAIN_W+DIFF_W:0] d_s3;
	drive_ctrl_t                   ctrl_s3;

	logic signed [SUM_W-1:0] sum;
	logic signed [LIM_W-1:0] lim;
	logic signed [LIM_W-1:0] minv;
	logic signed [LIM_W-1:0] clamped;
	logic signed [LIM_W-1:0] cmag;
	logic signed [LIM_W-1:0] shifted;
	logic                    forced;

	// Product stage: one multiplier per term, registered
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3    <= $signed({1'b0, kp}) * err;
			i_s3    <= $signed({1'b0, ki}) * esum;
			d_s3    <= $signed({1'b0, kd}) * diff;
			ctrl_s3 <= ctrl;
		end
	end

	always_comb begin
		sum  = SUM_W'(p_s3) + SUM_W'(i_s3) + SUM_W'(d_s3);
		lim  = $signed(LIM_W'({out_limit, SCALE'(0)}));
		minv = $signed(LIM_W'({min_drive, SCALE'(0)}));
		if (sum > SUM_W'(lim))
			clamped = lim;
		else if (sum < -SUM_W'(lim))
			clamped = -lim;
		else
			clamped = LIM_W'(sum);
		cmag    = (clamped < 0) ? -clamped : clamped;
		forced  = (cmag < minv) && ctrl_s3.above_tol;
		shifted = clamped >>> SCALE;
		if (!ctrl_s3.run)
			drive = '0;
		else if (forced)
			drive = (clamped > 0) ? $signed({1'b0, min_drive}) : -$signed({1'b0, min_drive});
		else
			drive = shifted[DRIVE_W-1:0];
		status = ctrl_s3.status;
	end

endmodule

@@ src/position_pid_with_windup_clamp.sv @@
`timescale 1ns / 1ps
// Position PID controller with integral clamp, one request per control tick.
// Input stream s_axis: tuser carries start_req, tdata the two encoder positions.
// Output stream m_axis: tdata carries the signed drive in millivolts, tuser the
// status (moving, reached target, timed out). Every request yields one result.
// Configuration channel cfg_*: register index and data, always ready; write it
// only while no request is in flight.
// A result passes the input register (loaded at the accepting edge), the error
// and integral stage, the product stage and the output register.
// Throughput: one request per cycle while the output is not stalled. The
// integral, last error, tick count and moving flag are updated in the error
// stage, so the next request sees them exactly when it reaches that stage.
// When m_axis_tready is low with a result held, the whole pipeline freezes and
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the loop state, the pipeline valids and loads the default
// gains and limits; the block then reports idle (status reached, drive zero).
// Start clears the integral, last error and tick count in the same tick.

module position_pid_with_windup_clamp
	import ppid_pkg::*;
#(
	parameter int TOLERANCE          = TOLERANCE_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_D_W-1:0]  cfg_data,
	// tick requests
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [2*POS_W-1:0]  s_axis_tdata,   // [23:0] left_position, [47:24] right_position
	input  logic [0:0]          s_axis_tuser,   // [0] start_req
	// drive results
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // [14:0] drive_voltage, [15] zero
	output logic [1:0]          m_axis_tuser    // [1:0] status
);

	// Configuration registers
	logic signed [TGT_W-1:0] target_q;
	logic [VOLT_W-1:0]       out_limit_q;
	logic [GAIN_W-1:0]       kp_q;
	logic [GAIN_W-1:0]       ki_q;
	logic [GAIN_W-1:0]       kd_q;
	logic [VOLT_W-1:0]       min_drive_q;
	logic [ILIM_W-1:0]       int_limit_q;
	logic [TICK_W-1:0]       timeout_q;

	// Loop state
	logic signed [ESUM_W-1:0] esum_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic [TICK_W-1:0]        ticks_q;
	logic                     moving_q;

	// Pipeline
	logic                     adv;
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     start_s1;
	logic signed [POS_W-1:0]  left_s1, right_s1;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [ESUM_W-1:0] esum_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	drive_ctrl_t              ctrl_s2;
	logic                     out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	status_t                  status_q;

	// Error stage signals
	logic                     eff_moving;
	logic [TICK_W-1:0]        eff_ticks;
	logic signed [ESUM_W-1:0] eff_esum;
	logic signed [ERR_W-1:0]  eff_prev;
	logic signed [POS_W+1:0]  pos_sum;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         mag;
	logic                     timed_out;
	logic                     in_band;
	logic signed [ESUM_W+5:0] esum_raw;
	logic signed [ESUM_W+5:0] ilim;
	logic signed [ESUM_W-1:0] esum_next;
	drive_ctrl_t              ctrl_next;
	logic                     state_we;

	logic signed [DRIVE_W-1:0] drive_c;
	status_t                   status_c;

	// Advance the whole pipeline whenever the output slot is free or being taken
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TARGET_RST;
			out_limit_q <= OUT_LIMIT_RST;
			kp_q        <= KP_RST;
			ki_q        <= KI_RST;
			kd_q        <= KD_RST;
			min_drive_q <= MIN_DRIVE_RST;
			int_limit_q <= INT_LIMIT_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TARGET:    target_q    <= cfg_data[TGT_W-1:0];
				CFG_OUT_LIMIT: out_limit_q <= cfg_data[VOLT_W-1:0];
				CFG_KP:        kp_q        <= cfg_data[GAIN_W-1:0];
				CFG_KI:        ki_q        <= cfg_data[GAIN_W-1:0];
				CFG_KD:        kd_q        <= cfg_data[GAIN_W-1:0];
				CFG_MIN_DRIVE: min_drive_q <= cfg_data[VOLT_W-1:0];
				CFG_INT_LIMIT: int_limit_q <= cfg_data[ILIM_W-1:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv) begin
			start_s1 <= s_axis_tuser[0];
			left_s1  <= s_axis_tdata[POS_W-1:0];
			right_s1 <= s_axis_tdata[2*POS_W-1:POS_W];
		end
	end

	// Error stage: start clears the state first, then decide timeout, arrival or drive
	always_comb begin
		eff_moving = start_s1 || moving_q;
		eff_ticks  = start_s1 ? '0 : ticks_q;
		eff_esum   = start_s1 ? '0 : esum_q;
		eff_prev   = start_s1 ? '0 : prev_err_q;

		pos_sum   = (POS_W+2)'(left_s1) + (POS_W+2)'(right_s1);
		err       = $signed({target_q, 1'b0}) - ERR_W'(pos_sum);
		mag       = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
		timed_out = eff_ticks >= timeout_q;
		in_band   = mag < ERR_W'(2 * TOLERANCE);

		// Anti-windup: add the error, then clamp to twice the integral limit
		ilim     = $signed((ESUM_W+6)'({int_limit_q, 1'b0}));
		esum_raw = (ESUM_W+6)'(eff_esum) + (ESUM_W+6)'(err);
		if (esum_raw > ilim)
			esum_next = ESUM_W'(ilim);
		else if (esum_raw < -ilim)
			esum_next = ESUM_W'(-ilim);
		else
			esum_next = ESUM_W'(esum_raw);

		ctrl_next.above_tol = mag > ERR_W'(2 * TOLERANCE);
		ctrl_next.run       = 1'b0;
		if (!eff_moving)
			ctrl_next.status = timed_out ? ST_TIMEOUT : ST_REACHED;
		else if (timed_out)
			ctrl_next.status = ST_TIMEOUT;
		else if (in_band)
			ctrl_next.status = ST_REACHED;
		else begin
			ctrl_next.status = ST_MOVING;
			ctrl_next.run    = 1'b1;
		end
	end

	assign state_we = adv && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q     <= '0;
			prev_err_q <= '0;
			ticks_q    <= '0;
			moving_q   <= 1'b0;
		end else if (state_we && eff_moving) begin
			if (ctrl_next.run) begin
				esum_q     <= esum_next;
				prev_err_q <= err;
				ticks_q    <= (eff_ticks != '1) ? eff_ticks + 1'b1 : eff_ticks;
				moving_q   <= 1'b1;
			end else begin
				// Move ends; keep whatever start cleared
				esum_q     <= eff_esum;
				prev_err_q <= eff_prev;
				ticks_q    <= eff_ticks;
				moving_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2  <= err;
			esum_s2 <= esum_next;
			diff_s2 <= DIFF_W'(err) - DIFF_W'(eff_prev);
			ctrl_s2 <= ctrl_next;
		end
	end

	ppid_drive #(
		.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
	) u_drive (
		.clk       (clk),
		.en        (adv),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.out_limit (out_limit_q),
		.min_drive (min_drive_q),
		.err       (err_s2),
		.esum      (esum_s2),
		.diff      (diff_s2),
		.ctrl      (ctrl_s2),
		.drive     (drive_c),
		.status    (status_c)
	);

	// Valid bits of every stage advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= s_axis_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q  <= drive_c;
			status_q <= status_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, drive_q};
	assign m_axis_tuser  = status_q;

`ifndef SYNTH
	// A finished or idle tick never drives the motors
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_MOVING) |-> (drive_q == '0))
		else $error("nonzero drive with status other than moving");

	// A start tick leaves at most one counted tick behind
	a_start_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_we && start_s1) |=> (ticks_q <= TICK_W'(1)))
		else $error("tick count not cleared by start");

	// An idle tick without start leaves the integral alone
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_we && !start_s1 && !moving_q) |=> $stable(esum_q))
		else $error("integral changed while idle");
`endif

endmodule

@@ bench/tb_position_pid_with_windup_clamp.sv @@
`timescale 1ns / 1ps

module tb_position_pid_with_windup_clamp;
	import ppid_pkg::*;

	localparam int     PHASES       = 16;
	localparam int     PHASE_TICKS  = 105;   // at least this many requests generated per random phase
	localparam int     DRAIN_CYCLES = 8;     // pipeline is 4 deep
	localparam int     LONG_STALL   = 300;   // receiver hold-off in cycles
	localparam int     FRAC_SHIFT   = GAIN_FRAC_DEF + 1;  // gain fraction plus half-degree bit
	localparam longint SCALE        = 64'sd1 << FRAC_SHIFT;
	localparam longint TOL2         = 2 * TOLERANCE_DEF;  // tolerance in half degrees
	localparam longint POS_MAX      = 64'sd8388607;
	localparam longint POS_MIN      = -64'sd8388608;

	// One control tick request and the drive it should produce
	typedef struct {
		logic                    start;
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] right;
	} tick_req_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		status_t                   status;
	} drive_res_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index     = CFG_TARGET;
	logic [CFG_D_W-1:0] cfg_data      = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [2*POS_W-1:0] s_axis_tdata  = '0;   // [23:0] left_position, [47:24] right_position
	logic [0:0]         s_axis_tuser  = '0;   // [0] start_req
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [15:0]        m_axis_tdata;         // [14:0] drive_voltage, [15] zero
	logic [1:0]         m_axis_tuser;         // [1:0] status

	position_pid_with_windup_clamp u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Shadow copy of the register file, loaded with the reset values
	longint tgt_q  = longint'(signed'(TARGET_RST));
	longint olim_q = longint'(OUT_LIMIT_RST);
	longint kp_q   = longint'(KP_RST);
	longint ki_q   = longint'(KI_RST);
	longint kd_q   = longint'(KD_RST);
	longint mind_q = longint'(MIN_DRIVE_RST);
	longint ilim_q = longint'(INT_LIMIT_RST);
	longint tmo_q  = longint'(TIMEOUT_RST);

	// Shadow loop state: integral and last error in half degrees
	longint err_sum  = 0;
	longint last_err = 0;
	longint tick_cnt = 0;
	bit     in_move  = 1'b0;

	tick_req_t  tick_pending[$];     // requests not yet offered
	drive_res_t drive_expected[$];   // drives owed by the block, oldest first
	tick_req_t  offered;
	drive_res_t head;

	int ticks_queued   = 0;
	int ticks_accepted = 0;
	int err_count      = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_ticket   = 0;   // bumped by the sequencer to request a long hold-off
	int stall_seen     = 0;
	int stall_left     = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Work out the drive and status for one accepted request and queue them
	function automatic void predict_drive(input tick_req_t t);
		longint     err;
		longint     mag;
		longint     acc;
		longint     lim;
		drive_res_t r;
		r.drive = '0;
		if (t.start) begin
			err_sum  = 0;
			last_err = 0;
			tick_cnt = 0;
			in_move  = 1'b1;
		end
		if (!in_move) begin
			// idle: report timeout if the count already ran out, else arrival
			r.status = (tick_cnt >= tmo_q) ? ST_TIMEOUT : ST_REACHED;
		end else if (tick_cnt >= tmo_q) begin
			in_move  = 1'b0;
			r.status = ST_TIMEOUT;
		end else begin
			err = 2 * tgt_q - (longint'(t.left) + longint'(t.right));
			mag = (err < 0) ? -err : err;
			if (mag < TOL2) begin
				in_move  = 1'b0;
				r.status = ST_REACHED;
			end else begin
				// clamp the integral before it feeds the sum
				err_sum += err;
				if (err_sum > 2 * ilim_q) err_sum = 2 * ilim_q;
				if (err_sum < -2 * ilim_q) err_sum = -2 * ilim_q;
				acc = kp_q * err + ki_q * err_sum + kd_q * (err - last_err);
				lim = olim_q * SCALE;
				if (acc > lim) acc = lim;
				if (acc < -lim) acc = -lim;
				// minimum drive overrides the limit; zero goes negative;
				// an error right at the tolerance is never forced
				if (((acc < 0) ? -acc : acc) < mind_q * SCALE && mag > TOL2)
					r.drive = DRIVE_W'((acc > 0) ? mind_q : -mind_q);
				else
					r.drive = DRIVE_W'(acc >>> FRAC_SHIFT);
				last_err = err;
				if (tick_cnt < 65535) tick_cnt++;
				r.status = ST_MOVING;
			end
		end
		drive_expected.push_back(r);
	endfunction

	function automatic longint sat_pos(input longint v);
		return (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
	endfunction

	function automatic longint rand_pos();
		logic signed [POS_W-1:0] v;
		v = POS_W'($urandom());
		return longint'(v);
	endfunction

	task automatic push_tick(input bit start, input longint l, input longint r);
		tick_req_t t;
		t.start = start;
		t.left  = POS_W'(l);
		t.right = POS_W'(r);
		tick_pending.push_back(t);
		ticks_queued++;
	endtask

	// Write one register and mirror it once the write handshake completes
	task automatic write_reg(input cfg_idx_t idx, input longint val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_D_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET:    tgt_q  = val;
			CFG_OUT_LIMIT: olim_q = val;
			CFG_KP:        kp_q   = val;
			CFG_KI:        ki_q   = val;
			CFG_KD:        kd_q   = val;
			CFG_MIN_DRIVE: mind_q = val;
			CFG_INT_LIMIT: ilim_q = val;
			CFG_TIMEOUT:   tmo_q  = val;
			default: ;
		endcase
	endtask

	task automatic flag_error(input string msg);
		err_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Request driver: predict on acceptance, then offer the next pending
	// request unless this cycle is picked to idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_drive(offered);
				ticks_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = tick_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {offered.right, offered.left};
					s_axis_tuser  <= offered.start;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted drive against the oldest
	// expectation, then pick tready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_expected.size() == 0) begin
					flag_error($sformatf("unexpected result: expected none, got drive %0d status %0d",
						$signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tuser));
				end else begin
					head = drive_expected.pop_front();
					if (m_axis_tdata !== {1'b0, head.drive} || m_axis_tuser !== head.status)
						flag_error($sformatf(
							"mismatch: expected drive %0d status %0d, got drive %0d status %0d (tdata %h)",
							head.drive, head.status, $signed(m_axis_tdata[DRIVE_W-1:0]),
							m_axis_tuser, m_axis_tdata));
				end
			end
			if (stall_ticket != stall_seen) begin
				stall_seen = stall_ticket;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				// long hold-off: let the pipeline fill and back up the input
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Sequencer: reset, then phases of register writes and request batches;
	// each phase drains fully before the registers change
	initial begin
		int     ph;
		int     k;
		int     move_len;
		longint t_v, ol_v, kp_v, ki_v, kd_v, md_v, il_v, to_v;
		longint pos;
		longint skew;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			// rotate through no idling, sender idle, receiver stall, both
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase

			if (ph == 0) begin
				// reset settings: idle ticks, field extremes, tolerance edges
				push_tick(1'b0, 0, 0);
				push_tick(1'b0, POS_MIN, POS_MAX);
				push_tick(1'b1, 1000, 1000);
				push_tick(1'b0, POS_MIN, POS_MIN);
				push_tick(1'b0, POS_MAX, POS_MAX);
				push_tick(1'b0, -5, -5);            // error right at the tolerance
				push_tick(1'b0, -5, -4);            // just inside: arrival
				push_tick(1'b0, 7, 7);              // idle after arrival
				push_tick(1'b1, -5, -5);            // first tick, zero last error
				push_tick(1'b0, -6, -6);
				push_tick(1'b0, 6, 6);              // small negative drive
				push_tick(1'b0, 6, 7);
				push_tick(1'b0, 3, 2);
				push_tick(1'b1, 100, -100);         // arrival on the start tick
				push_tick(1'b1, 2000, 2500);
				push_tick(1'b0, POS_MAX, POS_MIN);
			end else begin
				case (ph)
					1: begin
						// zero gains, limit below the minimum drive, short timeout
						t_v = 0; ol_v = 100; kp_v = 0; ki_v = 0; kd_v = 0;
						md_v = 1500; il_v = 3000; to_v = 3;
					end
					2: begin
						t_v = POS_MAX; ol_v = 12000; kp_v = 65535; ki_v = 65535;
						kd_v = 65535; md_v = 0; il_v = 1048575; to_v = 65535;
					end
					3: begin
						t_v = POS_MIN; ol_v = 0; kp_v = 2000; ki_v = 300;
						kd_v = 0; md_v = 12000; il_v = 0; to_v = 40;
					end
					default: begin
						t_v  = ($urandom_range(3) == 0) ? rand_pos()
							: longint'($urandom_range(40000)) - 20000;
						ol_v = longint'($urandom_range(12000));
						kp_v = longint'(($urandom_range(3) == 0) ? $urandom_range(65535)
							: $urandom_range(4096));
						ki_v = longint'(($urandom_range(2) == 0) ? 0
							: (($urandom_range(3) == 0) ? $urandom_range(65535)
							: $urandom_range(600)));
						kd_v = longint'(($urandom_range(3) == 0) ? $urandom_range(65535)
							: $urandom_range(30000));
						md_v = longint'(($urandom_range(4) == 0) ? $urandom_range(12000)
							: $urandom_range(2500));
						il_v = longint'(($urandom_range(4) == 0) ? $urandom_range(1048575)
							: $urandom_range(4000));
						to_v = longint'(($urandom_range(5) == 0) ? $urandom_range(65535)
							: $urandom_range(60));
						if (ph == 5) to_v = 0;
					end
				endcase
				write_reg(CFG_TARGET, t_v);
				write_reg(CFG_OUT_LIMIT, ol_v);
				write_reg(CFG_KP, kp_v);
				write_reg(CFG_KI, ki_v);
				write_reg(CFG_KD, kd_v);
				write_reg(CFG_MIN_DRIVE, md_v);
				write_reg(CFG_INT_LIMIT, il_v);
				write_reg(CFG_TIMEOUT, to_v);
				cfg_valid <= 1'b0;

				if (ph == 1) begin
					// zero sum is forced to the negative minimum, then time out
					push_tick(1'b1, 50, 50);
					push_tick(1'b0, 50, 50);
					push_tick(1'b0, 60, 40);
					push_tick(1'b0, 50, 50);
					push_tick(1'b0, 0, 0);
					push_tick(1'b1, -40, -40);
				end

				// Mostly closed-loop moves that settle on the target, some
				// without a start, plus raw noise across the full range
				while (tick_pending.size() < PHASE_TICKS) begin
					if ($urandom_range(4) == 0) begin
						push_tick($urandom_range(7) == 0, rand_pos(), rand_pos());
					end else begin
						move_len = $urandom_range(3, 30);
						pos = tgt_q + (($urandom_range(3) == 0) ? rand_pos()
							: longint'($urandom_range(8000)) - 4000);
						for (k = 0; k < move_len; k++) begin
							skew = longint'($urandom_range(6)) - 3;
							push_tick(k == 0 && $urandom_range(9) != 0,
								sat_pos(pos + skew), sat_pos(pos - skew));
							pos = pos + ((tgt_q - pos) * longint'($urandom_range(1, 6))) / 8
								+ longint'($urandom_range(4)) - 2;
						end
					end
				end

				// hold the receiver off while the sender keeps pushing
				if (ph == 4)
					stall_ticket++;
			end

			// pause the sender side until every owed drive has come back
			while (ticks_accepted != ticks_queued || drive_expected.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
